/* rtl/apr_pkg.sv */
// ----------------------------------------------------------------------------
// apr_pkg
// Shared types and constants for the ping-pong audio rate matcher.
// ----------------------------------------------------------------------------
package apr_pkg;

  localparam int BANK_WORDS_DEFAULT = 256;

  localparam int SAMPLE_W  = 24;
  localparam int ADDR_IN_W = 8;
  localparam int REM_W     = 9;
  localparam int ADJ_W     = 2;
  localparam int GAP_W     = 16;
  localparam int CNT_W     = 6;

  localparam int NOMINAL_PAIRS = 48;

  localparam logic [ADJ_W-1:0] ADJ_NOMINAL = 2'd0;
  localparam logic [ADJ_W-1:0] ADJ_SLOW    = 2'd1;
  localparam logic [ADJ_W-1:0] ADJ_FAST    = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;  // write one sample word
    logic load;   // capture the packet request fields
    logic calc;   // capture the rate decision
    logic fetch;  // read one pair and step the read position
    logic last;   // the pair being fetched ends the packet
  } apr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ADJ_W-1:0] adj;
  } apr_status_t;

endpackage

/* rtl/apr_controller.sv */
// ----------------------------------------------------------------------------
// apr_controller
// Sequencer for sample writes and packet requests of the rate matcher.
// ----------------------------------------------------------------------------
module apr_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                mode,
  input  apr_pkg::apr_status_t status,
  output apr_pkg::apr_cmd_t   cmd,
  output logic                busy
);
  import apr_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CALC  = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && (state == ST_IDLE);

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (mode) begin
            cmd.load   = 1'b1;
            state_next = ST_CALC;
          end else begin
            cmd.store = 1'b1;
          end
        end
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
        // The counter holds the number of pairs still to fetch after this one.
        case (status.adj)
          ADJ_SLOW: count_next = CNT_W'(NOMINAL_PAIRS - 2);
          ADJ_FAST: count_next = CNT_W'(NOMINAL_PAIRS);
          default:  count_next = CNT_W'(NOMINAL_PAIRS - 1);
        endcase
        state_next = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        cmd.last  = (count == '0);
        if (count == '0) begin
          state_next = ST_IDLE;
        end else begin
          count_next = count - 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  a_req_to_calc: assert property (@(posedge clk) disable iff (rst)
    (accept && mode) |=> (state == ST_CALC))
    else $error("packet request did not enter the rate decision");

  a_calc_to_fetch: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC) |=> (state == ST_FETCH && count >= CNT_W'(NOMINAL_PAIRS - 2)))
    else $error("rate decision did not start the pair fetch");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.fetch && cmd.last) |=> (state == ST_IDLE))
    else $error("packet did not end after its last pair");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |-> (count <= CNT_W'(NOMINAL_PAIRS)))
    else $error("pair counter out of range");

endmodule

/* rtl/apr_datapath.sv */
// ----------------------------------------------------------------------------
// apr_datapath
// Ping-pong sample store, read position, gap arithmetic and result registers.
// ----------------------------------------------------------------------------
module apr_datapath #(
  parameter int BANK_WORDS = apr_pkg::BANK_WORDS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  apr_pkg::apr_cmd_t                 cmd,
  output apr_pkg::apr_status_t              status,
  input  logic                              cfg_write,
  input  logic                              cfg_data,
  input  logic                              write_bank,
  input  logic [apr_pkg::ADDR_IN_W-1:0]     write_addr,
  input  logic [apr_pkg::SAMPLE_W-1:0]      sample_word,
  input  logic [apr_pkg::REM_W-1:0]         dma_remaining,
  input  logic                              dma_bank,
  output logic                              out_valid,
  output logic [apr_pkg::SAMPLE_W-1:0]      left_sample,
  output logic [apr_pkg::SAMPLE_W-1:0]      right_sample,
  output logic [apr_pkg::ADJ_W-1:0]         rate_adjust,
  output logic                              pair_is_last
);
  import apr_pkg::*;

  localparam int IDX_W   = $clog2(BANK_WORDS);
  localparam int MEM_A_W = IDX_W + 1;
  localparam int DEPTH   = 2 ** MEM_A_W;
  localparam int WA_W    = ((IDX_W > ADDR_IN_W) ? IDX_W : ADDR_IN_W) + 1;
  localparam int SUM_W   = GAP_W + 1;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  logic             mute;
  logic [IDX_W-1:0] read_index;
  logic             read_bank;
  logic [REM_W-1:0] rem_q;
  logic             dbank_q;
  logic [ADJ_W-1:0] adj_q;

  logic [SAMPLE_W-1:0] rd_left;
  logic [SAMPLE_W-1:0] rd_right;
  logic                mute_q;
  logic                right_zero_q;

  // Sample write addressing.
  logic [WA_W-1:0]    wa;
  logic               wa_ok;
  logic [MEM_A_W-1:0] waddr;

  assign wa    = WA_W'(write_addr);
  assign wa_ok = (wa < WA_W'(BANK_WORDS));
  assign waddr = {write_bank, wa[IDX_W-1:0]};

  // Pair read addressing and read position step.
  logic [IDX_W:0]     idx_right;
  logic [IDX_W:0]     idx_step;
  logic               right_past_end;
  logic [MEM_A_W-1:0] laddr;
  logic [MEM_A_W-1:0] raddr;

  assign idx_right      = {1'b0, read_index} + 1'b1;
  assign idx_step       = {1'b0, read_index} + 2'd2;
  assign right_past_end = (idx_right >= (IDX_W + 1)'(BANK_WORDS));
  assign laddr          = {read_bank, read_index};
  assign raddr          = {read_bank, idx_right[IDX_W-1:0]};

  // Gap between the read position and the DMA fill position, modulo 2^16.
  logic [SUM_W-1:0] sum;
  logic             ahead;
  logic [SUM_W-1:0] base;
  logic [SUM_W-1:0] gap_full;
  logic [GAP_W-1:0] gap;

  assign sum   = SUM_W'(read_index) + SUM_W'(rem_q);
  // The reader is behind the DMA in the shared bank; an oversized remaining
  // count always lands here because the fill position wraps to a huge value.
  assign ahead = (SUM_W'(rem_q) > SUM_W'(BANK_WORDS)) || (sum < SUM_W'(BANK_WORDS));

  always_comb begin
    if (dbank_q != read_bank) begin
      base = ahead ? SUM_W'(BANK_WORDS) : SUM_W'(3 * BANK_WORDS);
    end else begin
      base = SUM_W'(2 * BANK_WORDS);
    end
  end

  assign gap_full = base - sum;
  assign gap      = gap_full[GAP_W-1:0];

  always_comb begin
    if (gap < GAP_W'(BANK_WORDS / 2)) begin
      status.adj = ADJ_SLOW;
    end else if (gap > GAP_W'(BANK_WORDS + BANK_WORDS / 2)) begin
      status.adj = ADJ_FAST;
    end else begin
      status.adj = ADJ_NOMINAL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && wa_ok) begin
      mem[waddr] <= sample_word;
    end
    if (cmd.fetch) begin
      rd_left  <= mem[laddr];
      rd_right <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_q   <= dma_remaining;
      dbank_q <= dma_bank;
    end
    if (cmd.calc) begin
      adj_q <= status.adj;
    end
    if (cmd.fetch) begin
      mute_q       <= mute;
      right_zero_q <= right_past_end;
      pair_is_last <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mute       <= 1'b0;
      read_index <= '0;
      read_bank  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= cmd.fetch;
      if (cfg_write) begin
        mute <= cfg_data;
      end
      if (cmd.fetch && !mute) begin
        if (idx_step >= (IDX_W + 1)'(BANK_WORDS)) begin
          read_index <= '0;
          read_bank  <= ~read_bank;
        end else begin
          read_index <= idx_step[IDX_W-1:0];
        end
      end
    end
  end

  assign left_sample  = mute_q ? '0 : rd_left;
  assign right_sample = (mute_q || right_zero_q) ? '0 : rd_right;
  assign rate_adjust  = adj_q;

endmodule

/* rtl/audio_pingpong_rate_matcher.sv */
// ----------------------------------------------------------------------------
// audio_pingpong_rate_matcher
// Ping-pong stereo sample store with rate-matched packet readout.
// ----------------------------------------------------------------------------
// Usage: an input beat is taken at a rising edge with start high and busy
// low. With mode low the beat stores sample_word at write_bank/write_addr;
// busy stays low, and writes may follow every cycle while no packet runs.
// With mode high the beat is a packet request: busy rises for the gap
// arithmetic (CALC) state and stays high while the pairs are fetched.
// The first pair reaches the result ports after the CALC state and the
// registered store read of its fetch, and the pairs follow in consecutive
// cycles, each marked by out_valid for exactly one cycle; pair_is_last
// flags the final one. The packet length is set by the rate decision, one
// left/right pair a cycle through two read ports. The receiver cannot stall,
// so results are never held back. mute is written through cfg_write/cfg_data
// by the user while idle; the block does not enforce this. A muted packet
// gives zero samples and leaves the read position in place. A synchronous
// reset clears the read position to bank zero, index zero, clears mute and
// the strobe; the store contents are undefined until written.
// ----------------------------------------------------------------------------
module audio_pingpong_rate_matcher #(
  parameter int BANK_WORDS = apr_pkg::BANK_WORDS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_write,
  input  logic                          cfg_data,
  input  logic                          mode,
  input  logic                          write_bank,
  input  logic [apr_pkg::ADDR_IN_W-1:0] write_addr,
  input  logic [apr_pkg::SAMPLE_W-1:0]  sample_word,
  input  logic [apr_pkg::REM_W-1:0]     dma_remaining,
  input  logic                          dma_bank,
  output logic                          out_valid,
  output logic [apr_pkg::SAMPLE_W-1:0]  left_sample,
  output logic [apr_pkg::SAMPLE_W-1:0]  right_sample,
  output logic [apr_pkg::ADJ_W-1:0]     rate_adjust,
  output logic                          pair_is_last
);
  import apr_pkg::*;

  apr_cmd_t    cmd;
  apr_status_t status;

  apr_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  apr_datapath #(
    .BANK_WORDS (BANK_WORDS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .write_bank    (write_bank),
    .write_addr    (write_addr),
    .sample_word   (sample_word),
    .dma_remaining (dma_remaining),
    .dma_bank      (dma_bank),
    .out_valid     (out_valid),
    .left_sample   (left_sample),
    .right_sample  (right_sample),
    .rate_adjust   (rate_adjust),
    .pair_is_last  (pair_is_last)
  );

endmodule
